/* hw/rtl/pps_pkg.sv */
// pps_pkg: shared types and constants of the preemptive priority scheduler
// used by pps_ctrl, pps_dpath and preemptive_priority_scheduler

package pps_pkg;

    // fixed field widths
    localparam int unsigned TIME_W   = 16;
    localparam int unsigned PRIO_W   = 8;
    localparam int unsigned CLOCK_W  = 24;
    localparam int unsigned SUM_W    = 28;
    localparam int unsigned PID_W    = 5;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned S_DATA_W = 40;
    localparam int unsigned M_DATA_W = 160;

    localparam logic [CLOCK_W-1:0] CLOCK_MAX = {CLOCK_W{1'b1}};
    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};

    // operation codes carried on s_tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // result status codes carried on m_tuser
    localparam logic [STATUS_W-1:0] ST_LOADED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RAN      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_IDLE_RES = 2'd3;

    // one process table entry
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] burst;
        logic [TIME_W-1:0] remain;
        logic [TIME_W-1:0] arrival;
    } entry_t;

    // controller to datapath commands
    typedef struct packed {
        logic start;     // capture input item, clear per-item state
        logic load_wr;   // store a new process or reject it
        logic scan_rd;   // issue one table read for the priority scan
        logic update;    // advance time, service the picked process
        logic calc_tat;  // turnaround of a finished process
        logic calc_wt;   // waiting time and turnaround total
        logic calc_sum;  // waiting total
        logic out_load;  // move the result into the output register
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic empty;     // no process loaded
        logic scan_last; // current scan read is the last loaded entry
        logic out_free;  // output register can take a result
    } stat_t;

endpackage

/* hw/rtl/preemptive_priority_scheduler.sv */
// Preemptive priority scheduler over a table of up to MAX_PROCS processes. A load
// transfer (s_tuser 0) stores arrival, burst and priority under the next id; a
// tick transfer (s_tuser 1) scans the loaded entries one per cycle through the
// single read port of the process table. Each input transfer gives one result
// transfer. A new item is taken while a result still waits in the output
// register. Time and running totals saturate at their field maximum.
// depends on pps_pkg, pps_ctrl and pps_dpath

module preemptive_priority_scheduler #(
    parameter int unsigned MAX_PROCS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // arrival_time[15:0], burst_time[31:16], prio_level[39:32]
    input  logic [pps_pkg::S_DATA_W-1:0]   s_tdata,
    // op[0]
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // proc_id[4:0], time_now[28:5], finished[29], completion_time[53:30],
    // turnaround[77:54], waiting[101:78], all_done[102],
    // total_turnaround[130:103], total_waiting[158:131], zero pad[159]
    output logic [pps_pkg::M_DATA_W-1:0]   m_tdata,
    // status[1:0]
    output logic [pps_pkg::STATUS_W-1:0]   m_tuser
);

    pps_pkg::cmd_t  cmd;
    pps_pkg::stat_t stat;

    // sequencer
    pps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // table, scan and arithmetic
    pps_dpath #(
        .MAX_PROCS (MAX_PROCS)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* hw/rtl/pps_ctrl.sv */
// pps_ctrl: sequencing state machine of the priority scheduler
// depends on pps_pkg for command and status types

module pps_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    input  logic           s_op,
    output logic           s_tready,
    input  pps_pkg::stat_t stat,
    output pps_pkg::cmd_t  cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_LOAD  = 9'b000000010,
        S_SCAN  = 9'b000000100,
        S_DRAIN = 9'b000001000,
        S_UPD   = 9'b000010000,
        S_TAT   = 9'b000100000,
        S_WT    = 9'b001000000,
        S_SUM   = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid & s_tready;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.start = 1'b1;
                    if (s_op == pps_pkg::OP_LOAD) begin
                        state_next = S_LOAD;
                    end else if (stat.empty) begin
                        state_next = S_UPD;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_LOAD: begin
                cmd.load_wr = 1'b1;
                state_next  = S_OUT;
            end
            S_SCAN: begin
                cmd.scan_rd = 1'b1;
                if (stat.scan_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_UPD;
            end
            S_UPD: begin
                cmd.update = 1'b1;
                state_next = S_TAT;
            end
            S_TAT: begin
                cmd.calc_tat = 1'b1;
                state_next   = S_WT;
            end
            S_WT: begin
                cmd.calc_wt = 1'b1;
                state_next  = S_SUM;
            end
            S_SUM: begin
                cmd.calc_sum = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* hw/rtl/pps_dpath.sv */
// pps_dpath: process table memory, priority scan, time and totals arithmetic
// depends on pps_pkg for entry, command and status types

module pps_dpath #(
    parameter int unsigned MAX_PROCS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  pps_pkg::cmd_t                      cmd,
    output pps_pkg::stat_t                     stat,
    input  logic [pps_pkg::S_DATA_W-1:0]       s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [pps_pkg::M_DATA_W-1:0]       m_tdata,
    output logic [pps_pkg::STATUS_W-1:0]       m_tuser
);

    localparam int unsigned CNT_W = $clog2(MAX_PROCS + 1);
    localparam int unsigned IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int unsigned TW    = pps_pkg::TIME_W;
    localparam int unsigned CW    = pps_pkg::CLOCK_W;
    localparam int unsigned SW    = pps_pkg::SUM_W;

    // process table
    pps_pkg::entry_t mem [MAX_PROCS];
    logic            mem_we;
    logic [IDX_W-1:0] mem_waddr;
    pps_pkg::entry_t mem_wdata;

    // captured input item
    logic [TW-1:0]             arr_in_reg;
    logic [TW-1:0]             burst_in_reg;
    logic [pps_pkg::PRIO_W-1:0] prio_in_reg;

    // block state
    logic [CNT_W-1:0] loaded_reg;
    logic [CNT_W-1:0] completed_reg;
    logic [CW-1:0]    time_reg;
    logic [SW-1:0]    sum_tat_reg;
    logic [SW-1:0]    sum_wt_reg;

    // scan pipeline
    logic [CNT_W-1:0] rd_idx_reg;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_ent_reg;
    pps_pkg::entry_t  rd_data_reg;
    logic             found_reg;
    logic [IDX_W-1:0] best_idx_reg;
    pps_pkg::entry_t  best_reg;

    // result of the item
    logic [pps_pkg::STATUS_W-1:0] res_status_reg;
    logic [pps_pkg::PID_W-1:0]    res_id_reg;
    logic                         res_fin_reg;
    logic [CW-1:0]                res_ct_reg;
    logic [CW-1:0]                res_tat_reg;
    logic [CW-1:0]                res_wt_reg;

    // output register
    logic                          m_tvalid_reg;
    logic [pps_pkg::M_DATA_W-1:0]  m_tdata_reg;
    logic [pps_pkg::STATUS_W-1:0]  m_tuser_reg;

    logic                          full;
    logic                          eligible;
    logic                          better;
    logic [CW-1:0]                 time_inc;
    logic [TW-1:0]                 remain_dec;
    logic [SW:0]                   sum_tat_add;
    logic [SW:0]                   sum_wt_add;
    logic                          all_done;
    logic [pps_pkg::M_DATA_W-1:0]  res_pack;

    assign full = (loaded_reg == CNT_W'(MAX_PROCS));

    // status toward the controller
    assign stat.empty     = (loaded_reg == '0);
    assign stat.scan_last = ((rd_idx_reg + CNT_W'(1)) == loaded_reg);
    assign stat.out_free  = ~m_tvalid_reg | m_tready;

    // scan compare: arrived, unfinished, and more urgent than the best so far
    assign eligible = (CW'(rd_data_reg.arrival) <= time_reg) && (rd_data_reg.remain != '0);
    assign better   = !found_reg
                   || (rd_data_reg.prio < best_reg.prio)
                   || ((rd_data_reg.prio == best_reg.prio)
                       && (rd_data_reg.arrival < best_reg.arrival));

    assign time_inc   = (time_reg == pps_pkg::CLOCK_MAX) ? time_reg : time_reg + CW'(1);
    assign remain_dec = best_reg.remain - TW'(1);

    assign sum_tat_add = {1'b0, sum_tat_reg} + (SW + 1)'(res_tat_reg);
    assign sum_wt_add  = {1'b0, sum_wt_reg} + (SW + 1)'(res_wt_reg);

    // table write port: new process on load, serviced process on update
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = best_idx_reg;
        mem_wdata = best_reg;
        if (cmd.load_wr) begin
            mem_we            = !full;
            mem_waddr         = loaded_reg[IDX_W-1:0];
            mem_wdata.prio    = prio_in_reg;
            mem_wdata.burst   = burst_in_reg;
            mem_wdata.remain  = burst_in_reg;
            mem_wdata.arrival = arr_in_reg;
        end else if (cmd.update) begin
            mem_we           = found_reg;
            mem_wdata.remain = remain_dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    // table read port for the scan
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_idx_reg[IDX_W-1:0]];
        rd_ent_reg  <= rd_idx_reg[IDX_W-1:0];
    end

    // input capture, zero burst counts as one unit
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            arr_in_reg   <= s_tdata[TW-1:0];
            burst_in_reg <= (s_tdata[2*TW-1:TW] == '0) ? TW'(1) : s_tdata[2*TW-1:TW];
            prio_in_reg  <= s_tdata[2*TW+pps_pkg::PRIO_W-1:2*TW];
        end
    end

    // scan index, read valid and best candidate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_idx_reg <= '0;
            rd_vld_reg <= 1'b0;
            found_reg  <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.scan_rd;
            if (cmd.start) begin
                rd_idx_reg <= '0;
                found_reg  <= 1'b0;
            end else begin
                if (cmd.scan_rd) begin
                    rd_idx_reg <= rd_idx_reg + CNT_W'(1);
                end
                if (rd_vld_reg && eligible && better) begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_vld_reg && eligible && better) begin
            best_idx_reg <= rd_ent_reg;
            best_reg     <= rd_data_reg;
        end
    end

    // counts, time and totals
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loaded_reg    <= '0;
            completed_reg <= '0;
            time_reg      <= '0;
            sum_tat_reg   <= '0;
            sum_wt_reg    <= '0;
        end else begin
            if (cmd.load_wr && !full) begin
                loaded_reg <= loaded_reg + CNT_W'(1);
            end
            if (cmd.update) begin
                time_reg <= time_inc;
                if (found_reg && (remain_dec == '0)) begin
                    completed_reg <= completed_reg + CNT_W'(1);
                end
            end
            if (cmd.calc_wt && res_fin_reg) begin
                sum_tat_reg <= sum_tat_add[SW] ? pps_pkg::SUM_MAX : sum_tat_add[SW-1:0];
            end
            if (cmd.calc_sum && res_fin_reg) begin
                sum_wt_reg <= sum_wt_add[SW] ? pps_pkg::SUM_MAX : sum_wt_add[SW-1:0];
            end
        end
    end

    // per-item result fields
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            res_status_reg <= pps_pkg::ST_IDLE_RES;
            res_id_reg     <= '0;
            res_fin_reg    <= 1'b0;
            res_ct_reg     <= '0;
            res_tat_reg    <= '0;
            res_wt_reg     <= '0;
        end
        if (cmd.load_wr) begin
            if (full) begin
                res_status_reg <= pps_pkg::ST_REJECTED;
            end else begin
                res_status_reg <= pps_pkg::ST_LOADED;
                res_id_reg     <= pps_pkg::PID_W'(loaded_reg + CNT_W'(1));
            end
        end
        if (cmd.update && found_reg) begin
            res_status_reg <= pps_pkg::ST_RAN;
            res_id_reg     <= pps_pkg::PID_W'(CNT_W'(best_idx_reg) + CNT_W'(1));
            if (remain_dec == '0) begin
                res_fin_reg <= 1'b1;
                res_ct_reg  <= time_inc;
            end
        end
        if (cmd.calc_tat && res_fin_reg) begin
            res_tat_reg <= res_ct_reg - CW'(best_reg.arrival);
        end
        if (cmd.calc_wt && res_fin_reg) begin
            res_wt_reg <= (res_tat_reg >= CW'(best_reg.burst))
                        ? res_tat_reg - CW'(best_reg.burst) : '0;
        end
    end

    // pack the result, lowest field first
    assign all_done = (completed_reg == loaded_reg);
    assign res_pack = {1'b0, sum_wt_reg, sum_tat_reg, all_done, res_wt_reg,
                       res_tat_reg, res_ct_reg, res_fin_reg, time_reg, res_id_reg};

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= res_pack;
            m_tuser_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* tb/pps_checker.sv */
`timescale 1ns / 100ps
// pps_checker: watches both stream channels of the scheduler, predicts every result
// from accepted input transfers and compares field by field; depends on pps_pkg

module pps_checker
    import pps_pkg::*;
#(
    parameter int unsigned MAX_PROCS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_DATA_W-1:0]   m_tdata,
    input  logic [STATUS_W-1:0]   m_tuser,
    output int                    fail_count,
    output int                    pending,
    output int                    results_seen,
    output int                    finished_seen,
    output int                    rejected_seen
);

    // one result transfer, unpacked
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PID_W-1:0]    proc_id;
        logic [CLOCK_W-1:0]  time_now;
        logic                finished;
        logic [CLOCK_W-1:0]  completion;
        logic [CLOCK_W-1:0]  turnaround;
        logic [CLOCK_W-1:0]  waiting;
        logic                all_done;
        logic [SUM_W-1:0]    total_turn;
        logic [SUM_W-1:0]    total_wait;
    } sched_result_t;

    // process table and scheduler state of the prediction
    logic [TIME_W-1:0]  tbl_arrival [MAX_PROCS];
    logic [TIME_W-1:0]  tbl_remain  [MAX_PROCS];
    logic [TIME_W-1:0]  tbl_burst   [MAX_PROCS];
    logic [PRIO_W-1:0]  tbl_prio    [MAX_PROCS];
    int                 loaded_cnt;
    int                 done_cnt;
    logic [CLOCK_W-1:0] clock_now;
    logic [SUM_W-1:0]   sum_turn;
    logic [SUM_W-1:0]   sum_wait;

    sched_result_t expected_results[$];

    initial begin
        fail_count    = 0;
        pending       = 0;
        results_seen  = 0;
        finished_seen = 0;
        rejected_seen = 0;
    end

    // one line per mismatch, printing capped, counting not
    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 30) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input int idx,
                               input logic [SUM_W-1:0] got, input logic [SUM_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                      idx, name, got, want));
        end
    endtask

    function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] acc,
                                                 input logic [CLOCK_W-1:0] inc);
        logic [SUM_W:0] s;
        s = {1'b0, acc} + (SUM_W + 1)'(inc);
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    // scheduler prediction for one accepted input transfer
    task automatic schedule_step(input logic op, input logic [TIME_W-1:0] arr,
                                 input logic [TIME_W-1:0] bst, input logic [PRIO_W-1:0] pr,
                                 output sched_result_t r);
        int pick;
        r = '0;
        if (op == OP_LOAD) begin
            if (loaded_cnt >= MAX_PROCS) begin
                r.status = ST_REJECTED;
            end else begin
                // zero burst is stored as one unit
                tbl_arrival[loaded_cnt] = arr;
                tbl_burst[loaded_cnt]   = (bst == '0) ? TIME_W'(1) : bst;
                tbl_remain[loaded_cnt]  = tbl_burst[loaded_cnt];
                tbl_prio[loaded_cnt]    = pr;
                loaded_cnt++;
                r.status  = ST_LOADED;
                r.proc_id = PID_W'(loaded_cnt);
            end
        end else begin
            // lowest priority number wins, then earlier arrival, then lower id
            pick = -1;
            for (int i = 0; i < loaded_cnt; i++) begin
                if (CLOCK_W'(tbl_arrival[i]) <= clock_now && tbl_remain[i] != '0) begin
                    if (pick < 0 || tbl_prio[i] < tbl_prio[pick] ||
                        (tbl_prio[i] == tbl_prio[pick] && tbl_arrival[i] < tbl_arrival[pick])) begin
                        pick = i;
                    end
                end
            end
            if (clock_now != CLOCK_MAX) begin
                clock_now = clock_now + CLOCK_W'(1);
            end
            if (pick < 0) begin
                r.status = ST_IDLE_RES;
            end else begin
                r.status   = ST_RAN;
                r.proc_id  = PID_W'(pick + 1);
                tbl_remain[pick] = tbl_remain[pick] - TIME_W'(1);
                if (tbl_remain[pick] == '0) begin
                    done_cnt++;
                    r.finished   = 1'b1;
                    r.completion = clock_now;
                    r.turnaround = clock_now - CLOCK_W'(tbl_arrival[pick]);
                    r.waiting    = (r.turnaround >= CLOCK_W'(tbl_burst[pick])) ?
                                   r.turnaround - CLOCK_W'(tbl_burst[pick]) : '0;
                    sum_turn = sat_sum(sum_turn, r.turnaround);
                    sum_wait = sat_sum(sum_wait, r.waiting);
                end
            end
        end
        r.time_now   = clock_now;
        r.all_done   = (done_cnt == loaded_cnt);
        r.total_turn = sum_turn;
        r.total_wait = sum_wait;
    endtask

    // compare result transfers, then predict from input transfers
    always @(posedge aclk) begin
        sched_result_t want;
        sched_result_t got;
        sched_result_t pred;
        if (!aresetn) begin
            loaded_cnt = 0;
            done_cnt   = 0;
            clock_now  = '0;
            sum_turn   = '0;
            sum_wait   = '0;
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.status     = m_tuser;
                got.proc_id    = m_tdata[4:0];
                got.time_now   = m_tdata[28:5];
                got.finished   = m_tdata[29];
                got.completion = m_tdata[53:30];
                got.turnaround = m_tdata[77:54];
                got.waiting    = m_tdata[101:78];
                got.all_done   = m_tdata[102];
                got.total_turn = m_tdata[130:103];
                got.total_wait = m_tdata[158:131];
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              results_seen));
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", results_seen, SUM_W'(got.status),
                                SUM_W'(want.status));
                    check_field("proc_id", results_seen, SUM_W'(got.proc_id),
                                SUM_W'(want.proc_id));
                    check_field("time_now", results_seen, SUM_W'(got.time_now),
                                SUM_W'(want.time_now));
                    check_field("finished", results_seen, SUM_W'(got.finished),
                                SUM_W'(want.finished));
                    check_field("completion_time", results_seen, SUM_W'(got.completion),
                                SUM_W'(want.completion));
                    check_field("turnaround", results_seen, SUM_W'(got.turnaround),
                                SUM_W'(want.turnaround));
                    check_field("waiting", results_seen, SUM_W'(got.waiting),
                                SUM_W'(want.waiting));
                    check_field("all_done", results_seen, SUM_W'(got.all_done),
                                SUM_W'(want.all_done));
                    check_field("total_turnaround", results_seen, got.total_turn,
                                want.total_turn);
                    check_field("total_waiting", results_seen, got.total_wait,
                                want.total_wait);
                    if (want.finished) begin
                        finished_seen++;
                    end
                    if (want.status == ST_REJECTED) begin
                        rejected_seen++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                schedule_step(s_tuser, s_tdata[15:0], s_tdata[31:16], s_tdata[39:32], pred);
                expected_results.push_back(pred);
            end
        end
        pending = expected_results.size();
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// tb_top: clock, reset, load/tick stimulus and result-side pacing for the
// scheduler; depends on pps_pkg, preemptive_priority_scheduler and pps_checker

module tb_top;
    import pps_pkg::*;

    localparam int unsigned MAX_PROCS    = 16;
    localparam int          RANDOM_ITEMS = 1780;
    localparam int          HOLD_AT      = 300;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          CYCLE_LIMIT  = 400000;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    logic                  s_tuser  = OP_LOAD;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    int fail_count;
    int pending;
    int results_seen;
    int finished_seen;
    int rejected_seen;

    int   items_sent    = 0;
    int   ticks_sent    = 0;
    int   loads_sent    = 0;
    int   results_taken = 0;
    int   rx_seen       = 0;
    int   rx_pause      = 0;
    logic rx_hold       = 1'b0;
    int   cycle_count   = 0;

    always #1 aclk = ~aclk;

    preemptive_priority_scheduler #(
        .MAX_PROCS (MAX_PROCS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    pps_checker #(
        .MAX_PROCS (MAX_PROCS)
    ) u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending       (pending),
        .results_seen  (results_seen),
        .finished_seen (finished_seen),
        .rejected_seen (rejected_seen)
    );

    // idle cycles before a transfer; every fourth stretch runs without gaps
    function automatic int draw_gap(input int idx);
        if ((idx / 150) % 4 == 2) begin
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    // offer one item after a random gap and hold it until the transfer
    task automatic send_item(input logic op, input logic [TIME_W-1:0] arr,
                             input logic [TIME_W-1:0] bst, input logic [PRIO_W-1:0] pr);
        int gap;
        gap = draw_gap(items_sent);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser  <= op;
        s_tdata  <= {pr, bst, arr};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        items_sent++;
        if (op == OP_TICK) begin
            ticks_sent++;
        end else begin
            loads_sent++;
        end
    endtask

    // count result transfers for the receiver pacing
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_taken <= results_taken + 1;
        end
    end

    // result side: random pause after each transfer, plus the long hold
    always @(negedge aclk) begin
        if (results_taken != rx_seen) begin
            rx_seen  = results_taken;
            rx_pause = draw_gap(results_taken);
        end
        if (!aresetn || rx_hold) begin
            m_tready <= 1'b0;
        end else if (rx_pause > 0) begin
            rx_pause = rx_pause - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial begin
        wait (items_sent >= HOLD_AT);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL preemptive_priority_scheduler");
            $finish;
        end
    end

    // stimulus and verdict
    initial begin
        logic [TIME_W-1:0] arr;
        logic [TIME_W-1:0] bst;
        logic [PRIO_W-1:0] pr;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // tick on an empty table is idle with all_done set
        send_item(OP_TICK, 16'hFFFF, 16'hFFFF, 8'hFF);
        // zero burst stored as one unit
        send_item(OP_LOAD, 16'd0, 16'd0, 8'd5);
        // same priority and arrival as id 1: lower id first
        send_item(OP_LOAD, 16'd0, 16'd3, 8'd5);
        // same priority, later arrival
        send_item(OP_LOAD, 16'd1, 16'd2, 8'd5);
        // most urgent, preempts at its arrival
        send_item(OP_LOAD, 16'd2, 16'd2, 8'd0);
        // least urgent
        send_item(OP_LOAD, 16'd3, 16'd1, 8'd255);
        // arrives late, leaves idle ticks with work outstanding
        send_item(OP_LOAD, 16'd40, 16'd1, 8'd0);
        repeat (14) send_item(OP_TICK, 16'($urandom), 16'($urandom), 8'($urandom));

        // random mix: table fills early, then ticks with rejected loads as noise
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (loads_sent < MAX_PROCS && $urandom_range(0, 9) == 0) begin
                if (loads_sent == MAX_PROCS - 1) begin
                    // last slot: all-ones arrival and burst, never arrives in this run
                    arr = 16'hFFFF;
                    bst = 16'hFFFF;
                    pr  = 8'd0;
                end else begin
                    arr = 16'(ticks_sent + $urandom_range(0, 80));
                    bst = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom_range(1, 120));
                    pr  = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) :
                                                        8'($urandom_range(0, 3));
                end
                send_item(OP_LOAD, arr, bst, pr);
            end else if (loads_sent >= MAX_PROCS && $urandom_range(0, 19) == 0) begin
                send_item(OP_LOAD, 16'($urandom), 16'($urandom), 8'($urandom));
            end else begin
                send_item(OP_TICK, 16'($urandom), 16'($urandom), 8'($urandom));
            end
        end
        s_tvalid <= 1'b0;

        // drain outstanding results, then watch for strays
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("run: %0d input transfers (%0d loads, %0d ticks), %0d results compared",
                 items_sent, loads_sent, ticks_sent, results_seen);
        $display("run: %0d completions, %0d loads turned away on a full table, %0d-cycle hold",
                 finished_seen, rejected_seen, HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("PASS preemptive_priority_scheduler");
        end else begin
            $display("FAIL preemptive_priority_scheduler");
        end
        $finish;
    end

endmodule

/* preemptive_priority_scheduler.f */
hw/rtl/pps_pkg.sv
hw/rtl/pps_ctrl.sv
hw/rtl/pps_dpath.sv
hw/rtl/preemptive_priority_scheduler.sv
tb/pps_checker.sv
tb/tb_top.sv
